FILE: rtl/smg_pkg.sv
// ----------------------------------------------------------------------------
// Six-axis sine generator package
// Shared widths, word types, register codes and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package smg_pkg;

	localparam int PHASE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int NUM_AXES     = 6;
	localparam int CW           = 34;

	localparam logic [31:0] CORDIC_START_X = 32'd652032874;
	localparam logic [18:0] DEG2RAD_Q24    = 19'd292818;
	localparam logic [26:0] TWO_PI_Q24     = 27'd105414357;

	localparam logic [2:0] REG_TRANS_FREQ = 3'd0;
	localparam logic [2:0] REG_ROT_FREQ   = 3'd1;
	localparam logic [2:0] REG_TRANS_AMP  = 3'd2;
	localparam logic [2:0] REG_ROT_AMP    = 3'd3;
	localparam logic [2:0] REG_TRANS_OFF  = 3'd4;
	localparam logic [2:0] REG_ROT_OFF    = 3'd5;
	localparam logic [2:0] REG_TRANS_BIAS = 3'd6;
	localparam logic [2:0] REG_ROT_BIAS   = 3'd7;

	typedef logic signed [CW-1:0] cw_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][CW-1:0] x;
		logic [NUM_AXES-1:0][CW-1:0] y;
		logic [NUM_AXES-1:0][CW-1:0] z;
		logic [NUM_AXES-1:0]         flip;
	} crd_t;

	function automatic logic [31:0] arc_turn(input logic [3:0] i);
		logic [31:0] a;
		case (i)
			4'd0:  a = 32'd536870912;
			4'd1:  a = 32'd316933406;
			4'd2:  a = 32'd167458907;
			4'd3:  a = 32'd85004756;
			4'd4:  a = 32'd42667331;
			4'd5:  a = 32'd21354465;
			4'd6:  a = 32'd10679838;
			4'd7:  a = 32'd5340245;
			4'd8:  a = 32'd2670163;
			4'd9:  a = 32'd1335087;
			4'd10: a = 32'd667544;
			4'd11: a = 32'd333772;
			4'd12: a = 32'd166886;
			4'd13: a = 32'd83443;
			4'd14: a = 32'd41722;
			4'd15: a = 32'd20861;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/smg_front.sv
// ----------------------------------------------------------------------------
// Phase front end
// Forms each axis' turn angle from time and frequency, folds it into the
// right half plane and seeds the rotation chain.
// ----------------------------------------------------------------------------
`default_nettype none

module smg_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [31:0]         time_now,
	input  wire logic [23:0]         trans_hz,
	input  wire logic [23:0]         rot_hz,
	input  wire logic [47:0]         trans_off,
	input  wire logic [47:0]         rot_off,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output smg_pkg::crd_t            out_data
);
	import smg_pkg::*;

	logic              v_s1, v_s2;
	logic [1:0][31:0]  ph_s1;
	crd_t              crd_s2, crd_d;
	logic              rdy1, rdy2;
	logic [95:0]       off_all;

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign off_all  = {rot_off, trans_off};

	always_comb begin
		logic [31:0] ang, angm;
		logic [15:0] off;
		cw_t         z0;
		crd_d = '0;
		for (int k = 0; k < NUM_AXES; k++) begin
			off  = off_all[16*k +: 16];
			ang  = ((k < 3) ? ph_s1[0] : ph_s1[1]) + {off, 16'd0};
			angm = {ang[31 -: PHASE_BITS], {(32-PHASE_BITS){1'b0}}};
			z0   = {{(CW-32){angm[31]}}, angm};
			crd_d.flip[k] = 1'b0;
			if (z0 > 34'sd1073741824) begin
				z0 = z0 - 34'sd2147483648;
				crd_d.flip[k] = 1'b1;
			end else if (z0 < -34'sd1073741824) begin
				z0 = z0 + 34'sd2147483648;
				crd_d.flip[k] = 1'b1;
			end
			crd_d.x[k] = {{(CW-32){1'b0}}, CORDIC_START_X};
			crd_d.y[k] = '0;
			crd_d.z[k] = z0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			ph_s1[0] <= {8'd0, trans_hz} * time_now;
			ph_s1[1] <= {8'd0, rot_hz} * time_now;
		end
		if (rdy2 && v_s1)
			crd_s2 <= crd_d;
	end

	assign out_valid = v_s2;
	assign out_data  = crd_s2;

endmodule

`default_nettype wire

FILE: rtl/smg_cordic_cell.sv
// ----------------------------------------------------------------------------
// Rotation cell
// One CORDIC micro-rotation for all six axes, registered, with handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module smg_cordic_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [3:0]    step,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire smg_pkg::crd_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output smg_pkg::crd_t      out_data
);
	import smg_pkg::*;

	logic v_q;
	crd_t d_q, nxt;

	assign in_ready = !v_q || out_ready;

	always_comb begin
		cw_t xk, yk, zk, at;
		nxt = in_data;
		at  = {{(CW-32){1'b0}}, arc_turn(step)};
		for (int k = 0; k < NUM_AXES; k++) begin
			xk = in_data.x[k];
			yk = in_data.y[k];
			zk = in_data.z[k];
			if (!zk[CW-1]) begin
				nxt.x[k] = xk - (yk >>> step);
				nxt.y[k] = yk + (xk >>> step);
				nxt.z[k] = zk - at;
			end else begin
				nxt.x[k] = xk + (yk >>> step);
				nxt.y[k] = yk - (xk >>> step);
				nxt.z[k] = zk + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (in_ready)
			v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			d_q <= nxt;
	end

	assign out_valid = v_q;
	assign out_data  = d_q;

endmodule

`default_nettype wire

FILE: rtl/smg_back.sv
// ----------------------------------------------------------------------------
// Setpoint back end
// Scales sine and cosine by amplitude and angular rate, adds bias,
// saturates and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module smg_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire smg_pkg::crd_t      in_data,
	input  wire logic [23:0]        trans_hz,
	input  wire logic [23:0]        rot_hz,
	input  wire logic [47:0]        trans_amp,
	input  wire logic [47:0]        rot_amp,
	input  wire logic [47:0]        trans_bias,
	input  wire logic [47:0]        rot_bias,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [5:0][31:0]        pos,
	output logic [5:0][31:0]        vel
);
	import smg_pkg::*;

	logic [5:0][31:0] a24_q;
	logic [1:0][26:0] w_q;
	logic [5:0][34:0] av_q;

	logic             v_s1, v_s2, v_s3;
	logic             rdy1, rdy2, rdy3;
	logic [5:0][24:0] s_s1, c_s1;
	logic [5:0][57:0] pp_s2;
	logic [5:0][60:0] vp_s2;
	logic [5:0][31:0] pos_s3, vel_s3;
	logic [95:0]      amp_all, bias_all;

	assign amp_all  = {rot_amp, trans_amp};
	assign bias_all = {rot_bias, trans_bias};

	// coefficients are registered: a24_q and w_q from the settings, av_q from a24_q and w_q
	always_ff @(posedge clk) begin
		logic [34:0] ta;
		logic [50:0] tw;
		logic [58:0] tv;
		for (int k = 0; k < NUM_AXES; k++) begin
			if (k < 3) begin
				a24_q[k] <= {amp_all[16*k +: 16], 16'd0};
			end else begin
				ta = 35'(amp_all[16*k +: 16]) * 35'(DEG2RAD_Q24) + 35'd128;
				a24_q[k] <= {5'd0, ta[34:8]};
			end
			tv = 59'(a24_q[k]) * 59'(w_q[(k < 3) ? 0 : 1]) + 59'd8388608;
			av_q[k] <= tv[58:24];
		end
		tw = 51'(trans_hz) * 51'(TWO_PI_Q24) + 51'd8388608;
		w_q[0] <= tw[50:24];
		tw = 51'(rot_hz) * 51'(TWO_PI_Q24) + 51'd8388608;
		w_q[1] <= tw[50:24];
	end

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [35:0] xv, yv, xr, yr;
		logic signed [57:0] pr;
		logic signed [60:0] vr;
		if (rdy1 && in_valid) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				xv = {{2{in_data.x[k][CW-1]}}, in_data.x[k]};
				yv = {{2{in_data.y[k][CW-1]}}, in_data.y[k]};
				if (in_data.flip[k]) begin
					xv = -xv;
					yv = -yv;
				end
				xr = (xv + 36'sd128) >>> 8;
				yr = (yv + 36'sd128) >>> 8;
				c_s1[k] <= xr[24:0];
				s_s1[k] <= yr[24:0];
			end
		end
		if (rdy2 && v_s1) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				pp_s2[k] <= $signed({1'b0, a24_q[k]}) * $signed(s_s1[k]);
				vp_s2[k] <= $signed({1'b0, av_q[k]}) * $signed(c_s1[k]);
			end
		end
		if (rdy3 && v_s2) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				pr = ($signed(pp_s2[k]) + 58'sd536870912) >>> 30;
				pr = pr + (58'($signed(bias_all[16*k +: 16])) <<< 8);
				vr = ($signed(vp_s2[k]) + 61'sd2097152) >>> 22;
				pos_s3[k] <= sat32(64'(pr));
				vel_s3[k] <= sat32(64'(vr));
			end
		end
	end

	assign out_valid = v_s3;
	assign pos       = pos_s3;
	assign vel       = vel_s3;

endmodule

`default_nettype wire

FILE: rtl/six_axis_sine_motion_generator_core.sv
// ----------------------------------------------------------------------------
// Six-axis sine motion generator
// Each time word in gives position and velocity setpoints for surge, sway,
// heave, roll, pitch and yaw.
//
// Input channel: in_valid / in_stall with time_now (Q16.16 s).
// Output channel: out_valid / out_stall with twelve Q24.8 setpoints.
// Settings sit behind the APB port, one 64-bit register every 8 bytes.
// The pipeline has two phase stages, sixteen rotation cells and three
// scaling stages. One word enters per cycle unless refused; every stage
// holds its own valid bit, so gaps close up and input is refused only
// when all stages are full and out_stall is high. A stalled output word
// holds. Amplitude and rate coefficients are registered in smg_back from
// the settings. Reset empties the pipeline and clears every setting to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module six_axis_sine_motion_generator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] time_now,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      surge_pos,
	output logic [31:0]      sway_pos,
	output logic [31:0]      heave_pos,
	output logic [31:0]      roll_pos,
	output logic [31:0]      pitch_pos,
	output logic [31:0]      yaw_pos,
	output logic [31:0]      surge_vel,
	output logic [31:0]      sway_vel,
	output logic [31:0]      heave_vel,
	output logic [31:0]      roll_vel,
	output logic [31:0]      pitch_vel,
	output logic [31:0]      yaw_vel
);
	import smg_pkg::*;

	logic [23:0] trans_hz_q, rot_hz_q;
	logic [47:0] trans_amp_q, rot_amp_q, trans_off_q, rot_off_q;
	logic [47:0] trans_bias_q, rot_bias_q;

	logic [2:0]  ridx;
	assign ridx   = paddr[5:3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_hz_q   <= '0;
			rot_hz_q     <= '0;
			trans_amp_q  <= '0;
			rot_amp_q    <= '0;
			trans_off_q  <= '0;
			rot_off_q    <= '0;
			trans_bias_q <= '0;
			rot_bias_q   <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				REG_TRANS_FREQ: trans_hz_q   <= pwdata[23:0];
				REG_ROT_FREQ:   rot_hz_q     <= pwdata[23:0];
				REG_TRANS_AMP:  trans_amp_q  <= pwdata[47:0];
				REG_ROT_AMP:    rot_amp_q    <= pwdata[47:0];
				REG_TRANS_OFF:  trans_off_q  <= pwdata[47:0];
				REG_ROT_OFF:    rot_off_q    <= pwdata[47:0];
				REG_TRANS_BIAS: trans_bias_q <= pwdata[47:0];
				REG_ROT_BIAS:   rot_bias_q   <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_TRANS_FREQ: prdata = {40'd0, trans_hz_q};
			REG_ROT_FREQ:   prdata = {40'd0, rot_hz_q};
			REG_TRANS_AMP:  prdata = {16'd0, trans_amp_q};
			REG_ROT_AMP:    prdata = {16'd0, rot_amp_q};
			REG_TRANS_OFF:  prdata = {16'd0, trans_off_q};
			REG_ROT_OFF:    prdata = {16'd0, rot_off_q};
			REG_TRANS_BIAS: prdata = {16'd0, trans_bias_q};
			REG_ROT_BIAS:   prdata = {16'd0, rot_bias_q};
			default:        prdata = '0;
		endcase
	end

	logic                    front_ready;
	logic [CORDIC_STEPS:0]   cv, cr;
	crd_t                    cd [CORDIC_STEPS+1];
	logic [5:0][31:0]        pos, vel;

	smg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (front_ready),
		.time_now   (time_now),
		.trans_hz   (trans_hz_q),
		.rot_hz     (rot_hz_q),
		.trans_off  (trans_off_q),
		.rot_off    (rot_off_q),
		.out_valid  (cv[0]),
		.out_ready  (cr[0]),
		.out_data   (cd[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		smg_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (4'(i)),
			.in_valid  (cv[i]),
			.in_ready  (cr[i]),
			.in_data   (cd[i]),
			.out_valid (cv[i+1]),
			.out_ready (cr[i+1]),
			.out_data  (cd[i+1])
		);
	end

	smg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cv[CORDIC_STEPS]),
		.in_ready   (cr[CORDIC_STEPS]),
		.in_data    (cd[CORDIC_STEPS]),
		.trans_hz   (trans_hz_q),
		.rot_hz     (rot_hz_q),
		.trans_amp  (trans_amp_q),
		.rot_amp    (rot_amp_q),
		.trans_bias (trans_bias_q),
		.rot_bias   (rot_bias_q),
		.out_valid  (out_valid),
		.out_ready  (!out_stall),
		.pos        (pos),
		.vel        (vel)
	);

	assign in_stall  = !front_ready;
	assign surge_pos = pos[0];
	assign sway_pos  = pos[1];
	assign heave_pos = pos[2];
	assign roll_pos  = pos[3];
	assign pitch_pos = pos[4];
	assign yaw_pos   = pos[5];
	assign surge_vel = vel[0];
	assign sway_vel  = vel[1];
	assign heave_vel = vel[2];
	assign roll_vel  = vel[3];
	assign pitch_vel = vel[4];
	assign yaw_vel   = vel[5];

endmodule

`default_nettype wire

FILE: rtl/smg_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the channels of the generator and counts words in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module smg_port_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall
);
	logic [4:0] cnt_q;
	logic       acc_in, acc_out;

	assign acc_in  = in_valid && !in_stall;
	assign acc_out = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + 5'(acc_in) - 5'(acc_out);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input refused with output free");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 5'd0)
		else $error("output word without input word");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'd21)
		else $error("more words in flight than stages");

endmodule

bind six_axis_sine_motion_generator_core smg_port_checker u_chk (.*);

`default_nettype wire

FILE: dv/smg_checker.sv
// ----------------------------------------------------------------------------
// Six-axis sine generator checker
// Mirrors the register file from the APB port, predicts the twelve setpoints
// for every accepted time word and compares them in order with the output.
// ----------------------------------------------------------------------------
`default_nettype none

module smg_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	input  wire logic        pready,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [31:0] time_now,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [11:0][31:0] setpoints,
	output int               fails,
	output int               pending
);
	import smg_pkg::*;

	typedef logic [11:0][31:0] sp_t;

	logic [23:0] t_freq, r_freq;
	logic [47:0] t_amp, r_amp, t_off, r_off, t_bias, r_bias;
	sp_t         setpoint_queue[$];

	string axis_names[12] = '{"surge_pos", "sway_pos", "heave_pos", "roll_pos",
		"pitch_pos", "yaw_pos", "surge_vel", "sway_vel", "heave_vel", "roll_vel",
		"pitch_vel", "yaw_vel"};

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic void sin_cos(logic [31:0] ang, output longint s, output longint c);
		longint z, x, y, nx;
		longint arcs[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861};
		bit flip;
		z = longint'($signed(ang));
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648;
			flip = 1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - asr(y, i);
				y = y + asr(x, i);
				z -= arcs[i];
			end else begin
				nx = x + asr(y, i);
				y = y - asr(x, i);
				z += arcs[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = rnd(y, 8);
		c = rnd(x, 8);
	endfunction

	function automatic void axis_setpoint(logic [31:0] t, logic [23:0] freq, longint a24,
			logic [15:0] off, logic [15:0] bias, output logic [31:0] pos,
			output logic [31:0] vel);
		logic [63:0] prod;
		logic [31:0] ang;
		longint s, c, w, av;
		prod = 64'(freq) * 64'(t);
		ang = prod[31:0] + {off, 16'h0};
		ang[31-PHASE_BITS:0] = '0;
		sin_cos(ang, s, c);
		pos = clip32(rnd(a24 * s, 30) + longint'($signed(bias)) * 256);
		w = rnd(longint'(freq) * 105414357, 24);
		av = rnd(a24 * w, 24);
		vel = clip32(rnd(av * c, 22));
	endfunction

	function automatic sp_t predict_setpoints(logic [31:0] t);
		sp_t r;
		logic [31:0] p, v;
		longint a;
		for (int k = 0; k < 3; k++) begin
			a = longint'(t_amp[16*k +: 16]) <<< 16;
			axis_setpoint(t, t_freq, a, t_off[16*k +: 16], t_bias[16*k +: 16], p, v);
			r[k] = p;
			r[6+k] = v;
			a = rnd(longint'(r_amp[16*k +: 16]) * 292818, 8);
			axis_setpoint(t, r_freq, a, r_off[16*k +: 16], r_bias[16*k +: 16], p, v);
			r[3+k] = p;
			r[9+k] = v;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sp_t exp_sp;
		int  nerr;
		nerr = 0;
		if (!arst_n) begin
			t_freq <= '0; r_freq <= '0;
			t_amp <= '0; r_amp <= '0; t_off <= '0; r_off <= '0;
			t_bias <= '0; r_bias <= '0;
			fails <= 0;
			pending <= 0;
			setpoint_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_TRANS_FREQ: t_freq <= pwdata[23:0];
					REG_ROT_FREQ:   r_freq <= pwdata[23:0];
					REG_TRANS_AMP:  t_amp <= pwdata[47:0];
					REG_ROT_AMP:    r_amp <= pwdata[47:0];
					REG_TRANS_OFF:  t_off <= pwdata[47:0];
					REG_ROT_OFF:    r_off <= pwdata[47:0];
					REG_TRANS_BIAS: t_bias <= pwdata[47:0];
					REG_ROT_BIAS:   r_bias <= pwdata[47:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				setpoint_queue.push_back(predict_setpoints(time_now));
			if (out_valid && !out_stall) begin
				if (setpoint_queue.size() == 0) begin
					$error("unexpected output word");
					nerr = nerr + 1;
				end else begin
					exp_sp = setpoint_queue.pop_front();
					for (int k = 0; k < 12; k++)
						if (exp_sp[k] !== setpoints[k]) begin
							$error("%s expected %h actual %h", axis_names[k], exp_sp[k],
								setpoints[k]);
							nerr = nerr + 1;
						end
				end
			end
			fails <= fails + nerr;
			pending <= setpoint_queue.size();
		end
	end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Six-axis sine generator testbench
// Sweeps register settings through the APB port and streams time words with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import smg_pkg::*;

	logic        clk = 0, arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0, prdata;
	logic        pready;
	logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [31:0] time_now = '0;
	wire  [11:0][31:0] setpoints;
	int          fails, pending;
	int          send_idle = 0, recv_stall = 0;

	six_axis_sine_motion_generator_core dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .time_now, .out_valid, .out_stall,
		.surge_pos(setpoints[0]), .sway_pos(setpoints[1]), .heave_pos(setpoints[2]),
		.roll_pos(setpoints[3]), .pitch_pos(setpoints[4]), .yaw_pos(setpoints[5]),
		.surge_vel(setpoints[6]), .sway_vel(setpoints[7]), .heave_vel(setpoints[8]),
		.roll_vel(setpoints[9]), .pitch_vel(setpoints[10]), .yaw_vel(setpoints[11])
	);

	smg_checker chk (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.in_valid, .in_stall, .time_now, .out_valid, .out_stall, .setpoints,
		.fails, .pending
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		#4000000;
		$display("tb failed");
		$finish;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall);

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 3'b000}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_time(logic [31:0] t);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		time_now <= t;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	task automatic set_all(logic [23:0] tf, logic [23:0] rf, logic [47:0] ta, logic [47:0] ra,
			logic [47:0] to_, logic [47:0] ro, logic [47:0] tb_, logic [47:0] rb);
		drain();
		write_reg(REG_TRANS_FREQ, {$urandom, 8'h0, tf});
		write_reg(REG_ROT_FREQ, {40'h0, rf});
		write_reg(REG_TRANS_AMP, {16'hFFFF, ta});
		write_reg(REG_ROT_AMP, {16'h0, ra});
		write_reg(REG_TRANS_OFF, {16'h0, to_});
		write_reg(REG_ROT_OFF, {16'h0, ro});
		write_reg(REG_TRANS_BIAS, {16'h0, tb_});
		write_reg(REG_ROT_BIAS, {16'h0, rb});
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		// directed: zero registers, then extremes
		send_time(32'h0);
		send_time(32'hFFFF_FFFF);
		set_all(24'hFFFFFF, 24'hFFFFFF, '1, '1, '1, '1, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000);
		send_time(32'h0);
		send_time(32'hFFFF_FFFF);
		send_time(32'h0001_0000);
		send_time(32'h8000_0000);
		drain();
		set_all(24'h0, 24'h0, 48'h0100_8000_FFFF, 48'h5A00_B400_0100, 48'h4000_8000_C000,
			48'h2000_6000_E000, 48'h8000_0000_7FFF, 48'h7FFF_8000_0001);
		send_time(32'h0);
		send_time(32'h1234_5678);
		drain();
		set_all(24'h010000, 24'h008000, 48'h0100_0100_0100, 48'h5A00_5A00_5A00,
			'0, '0, '0, '0);
		for (int i = 0; i < 16; i++)
			send_time(i * 32'h0000_1000);
		drain();
		for (int ph = 0; ph < 20; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 71; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 71; end
				default: begin send_idle = 14; recv_stall = 14; end
			endcase
			if (ph == 19)
				set_all('0, '0, '0, '0, '0, '0, '0, '0);
			else
				set_all(24'($urandom_range(ph % 3 == 0 ? 24'hFFFFFF : 24'h03FFFF)),
					24'($urandom), rand48(), rand48(), rand48(), rand48(), rand48(),
					rand48());
			for (int i = 0; i < 50; i++)
				send_time($urandom_range(1) ? $urandom : $urandom_range(32'h000F_FFFF));
			drain();
		end
		recv_stall = 0;
		if (fails == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/smg_pkg.sv
rtl/smg_front.sv
rtl/smg_cordic_cell.sv
rtl/smg_back.sv
rtl/six_axis_sine_motion_generator_core.sv
rtl/smg_checker.sv
dv/smg_checker.sv
dv/tb.sv
